>>> rtl/tpbb_pkg.sv
// ============================================================================
// tpbb_pkg: shared definitions for the transformed point bounding box
// Widths, reset values, register indexes and lane control for all modules.
// ============================================================================
package tpbb_pkg;

    localparam int COORD_BITS = 32;
    localparam int COEF_BITS  = 16;
    localparam int COEF_FRAC  = COEF_BITS - 4;
    localparam int NUM_AXES   = 3;
    localparam int ROW_BITS   = NUM_AXES * COEF_BITS;
    localparam int HALF_BITS  = COORD_BITS - 1;

    // Product, exact three-term sum, rounded sum and sum with translation.
    localparam int PROD_BITS  = COORD_BITS + COEF_BITS;
    localparam int SUM_BITS   = PROD_BITS + 2;
    localparam int RND_BITS   = SUM_BITS - COEF_FRAC;
    localparam int OFS_BITS   = RND_BITS + 1;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = ROW_BITS;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ROW_X = 3'd0,
        CFG_ROW_Y = 3'd1,
        CFG_ROW_Z = 3'd2,
        CFG_OFS_X = 3'd3,
        CFG_OFS_Y = 3'd4,
        CFG_OFS_Z = 3'd5
    } t_cfg_idx;

    // Identity matrix: 1.0 in Q4.12 on the diagonal.
    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1 << COEF_FRAC);
    localparam logic [ROW_BITS-1:0]  ROW_X_RESET = ROW_BITS'(COEF_ONE);
    localparam logic [ROW_BITS-1:0]  ROW_Y_RESET = ROW_BITS'(COEF_ONE) << COEF_BITS;
    localparam logic [ROW_BITS-1:0]  ROW_Z_RESET = ROW_BITS'(COEF_ONE) << (2 * COEF_BITS);

    localparam t_coord COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) << (COEF_FRAC - 1);

    typedef struct packed {
        logic s1_en;       // load the products of the accepted vertex
        logic s2_en;       // load the transformed coordinate
        logic fold_en;     // fold the transformed coordinate into the corners
        logic fold_final;  // the folded vertex closes the run
    } t_lane_ctrl;

endpackage

>>> rtl/tpbb_if.sv
// ============================================================================
// tpbb interfaces: vertex and box channels
// Valid/ready channels carrying one vertex or one finished box per beat.
// ============================================================================
interface tpbb_vertex_if import tpbb_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord vertex_x;
    t_coord vertex_y;
    t_coord vertex_z;
    logic   final_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                    output final_vertex, input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                    input final_vertex, output ready);
endinterface

interface tpbb_box_if import tpbb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_coord               center_x;
    t_coord               center_y;
    t_coord               center_z;
    logic [HALF_BITS-1:0] half_x;
    logic [HALF_BITS-1:0] half_y;
    logic [HALF_BITS-1:0] half_z;

    modport source (output valid, output center_x, output center_y, output center_z,
                    output half_x, output half_y, output half_z, input ready);
    modport sink   (input valid, input center_x, input center_y, input center_z,
                    input half_x, input half_y, input half_z, output ready);
endinterface

>>> rtl/tpbb_lane.sv
// ============================================================================
// tpbb_lane: one output axis of the transform and its running extent
// Multiplies, rounds, translates and saturates one coordinate, then folds it
// into this axis's minimum and maximum.
// ============================================================================
module tpbb_lane import tpbb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_lane_ctrl          i_ctrl,
    input  t_coord              i_vertex [NUM_AXES],
    input  logic [ROW_BITS-1:0] i_row,
    input  t_coord              i_offset,
    output t_coord              o_res_low,
    output t_coord              o_res_high
);

    logic signed [COEF_BITS-1:0] w_coef [NUM_AXES];
    logic signed [PROD_BITS-1:0] r_prod [NUM_AXES];
    logic signed [SUM_BITS-1:0]  w_sum;
    logic signed [SUM_BITS-1:0]  w_sum_rnd;
    logic signed [RND_BITS-1:0]  w_rnd;
    logic signed [OFS_BITS-1:0]  w_tot;
    logic signed [OFS_BITS-1:0]  w_sat_hi;
    logic signed [OFS_BITS-1:0]  w_sat_lo;
    t_coord                      n_point;
    t_coord                      r_point;
    t_coord                      r_low;
    t_coord                      r_high;
    t_coord                      n_low;
    t_coord                      n_high;
    t_coord                      r_res_low;
    t_coord                      r_res_high;

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            w_coef[k] = i_row[k*COEF_BITS +: COEF_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.s1_en) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_prod[k] <= PROD_BITS'(w_coef[k]) * PROD_BITS'(i_vertex[k]);
            end
        end
    end

    // Round once to Q16.16 with ties toward plus infinity, translate, saturate.
    always_comb begin
        w_sum     = SUM_BITS'(r_prod[0]) + SUM_BITS'(r_prod[1]) + SUM_BITS'(r_prod[2]);
        w_sum_rnd = w_sum + ROUND_HALF;
        w_rnd     = w_sum_rnd[SUM_BITS-1:COEF_FRAC];
        w_tot     = OFS_BITS'(w_rnd) + OFS_BITS'(i_offset);
        w_sat_hi  = OFS_BITS'(COORD_MAX);
        w_sat_lo  = OFS_BITS'(COORD_MIN);
        if (w_tot > w_sat_hi) begin
            n_point = COORD_MAX;
        end else if (w_tot < w_sat_lo) begin
            n_point = COORD_MIN;
        end else begin
            n_point = w_tot[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.s2_en) begin
            r_point <= n_point;
        end
    end

    always_comb begin
        n_low  = (r_point < r_low)  ? r_point : r_low;
        n_high = (r_point > r_high) ? r_point : r_high;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= COORD_MAX;
            r_high <= COORD_MIN;
        end else if (i_ctrl.fold_en) begin
            if (i_ctrl.fold_final) begin
                r_low  <= COORD_MAX;
                r_high <= COORD_MIN;
            end else begin
                r_low  <= n_low;
                r_high <= n_high;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fold_en && i_ctrl.fold_final) begin
            r_res_low  <= n_low;
            r_res_high <= n_high;
        end
    end

    assign o_res_low  = r_res_low;
    assign o_res_high = r_res_high;

endmodule

>>> rtl/tpbb_merge.sv
// ============================================================================
// tpbb_merge: box output stage
// Turns the three lanes' closed extents into center and half size and holds
// them in the output register until the receiver takes the beat.
// ============================================================================
module tpbb_merge import tpbb_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_coord        i_low  [NUM_AXES],
    input  t_coord        i_high [NUM_AXES],
    output logic          o_free,
    tpbb_box_if.source    o_box
);

    logic                   r_valid;
    t_coord                 r_center [NUM_AXES];
    logic [HALF_BITS-1:0]   r_half   [NUM_AXES];
    logic [COORD_BITS:0]    w_sum    [NUM_AXES];
    logic [COORD_BITS:0]    w_diff   [NUM_AXES];

    // Minimum plus half size equals the floor of the mean of the corners.
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_sum[a]  = {i_low[a][COORD_BITS-1], i_low[a]}
                      + {i_high[a][COORD_BITS-1], i_high[a]};
            w_diff[a] = {i_high[a][COORD_BITS-1], i_high[a]}
                      - {i_low[a][COORD_BITS-1], i_low[a]};
        end
    end

    assign o_free = !r_valid || o_box.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_center[a] <= w_sum[a][COORD_BITS:1];
                r_half[a]   <= w_diff[a][COORD_BITS-1:1];
            end
        end
    end

    assign o_box.valid    = r_valid;
    assign o_box.center_x = r_center[0];
    assign o_box.center_y = r_center[1];
    assign o_box.center_z = r_center[2];
    assign o_box.half_x   = r_half[0];
    assign o_box.half_y   = r_half[1];
    assign o_box.half_z   = r_half[2];

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && o_free |=> r_valid)
        else $error("loaded box did not reach the output register");

endmodule

>>> rtl/transformed_point_bounding_box.sv
// ============================================================================
// transformed_point_bounding_box: box of affinely transformed vertices
// Three axis lanes transform each vertex and track per-axis extents; a merge
// stage emits the center and half size at the end of every run.
// ============================================================================
// Usage. Vertices arrive on i_vertex, one per beat, in Q16.16. Each is
// multiplied by the 3x3 Q4.12 matrix in the row registers, rounded once,
// translated by the offset registers and saturated to 32 bits. A beat with
// final_vertex set closes the run: that vertex is folded in first, then one
// box beat (center and half size) goes out on o_box and the corners return
// to empty. Other vertices produce no output beat.
// Throughput is one vertex per cycle unless the input stalls: the three
// lanes work in parallel; the multiply, sum and fold stages are registered.
// The box beat passes the product, transformed point, fold and output
// registers in that order once the final vertex is accepted.
// Configuration writes through i_cfg_we/i_cfg_idx/i_cfg_data take effect at
// once; the user must make them only while no vertex is in flight (the
// block does not enforce it). Index 0..2: rows, 3..5: offsets, others ignored.
// Reset loads the identity matrix, zero offsets and empty corners.
// When the receiver stalls, the box waits in the output register and one
// more closed box waits in the lanes; vertices that do not close a run keep
// flowing into the corners, and the input stalls only when a final vertex
// finds both places taken.
// ============================================================================
module transformed_point_bounding_box import tpbb_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    tpbb_vertex_if.sink              i_vertex,
    tpbb_box_if.source               o_box
);

    logic [ROW_BITS-1:0] r_row    [NUM_AXES];
    t_coord              r_offset [NUM_AXES];
    t_coord              w_vertex [NUM_AXES];
    t_coord              w_res_low  [NUM_AXES];
    t_coord              w_res_high [NUM_AXES];

    logic       r_s1_valid;
    logic       r_s1_final;
    logic       r_s2_valid;
    logic       r_s2_final;
    logic       r_res_valid;
    logic       w_out_free;
    logic       w_res_load;
    logic       w_res_ready;
    logic       w_fold;
    logic       w_s2_ready;
    logic       w_s1_ready;
    logic       w_accept;
    t_lane_ctrl w_ctrl;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]    <= ROW_X_RESET;
            r_row[1]    <= ROW_Y_RESET;
            r_row[2]    <= ROW_Z_RESET;
            r_offset[0] <= '0;
            r_offset[1] <= '0;
            r_offset[2] <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW_X: r_row[0]    <= i_cfg_data;
                CFG_ROW_Y: r_row[1]    <= i_cfg_data;
                CFG_ROW_Z: r_row[2]    <= i_cfg_data;
                CFG_OFS_X: r_offset[0] <= i_cfg_data[COORD_BITS-1:0];
                CFG_OFS_Y: r_offset[1] <= i_cfg_data[COORD_BITS-1:0];
                CFG_OFS_Z: r_offset[2] <= i_cfg_data[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Stall chain, from the output backward. A vertex that does not close a
    // run always leaves the fold stage; a closing one needs the result slot.
    assign w_res_load  = r_res_valid && w_out_free;
    assign w_res_ready = !r_res_valid || w_out_free;
    assign w_fold      = r_s2_valid && (!r_s2_final || w_res_ready);
    assign w_s2_ready  = !r_s2_valid || w_fold;
    assign w_s1_ready  = !r_s1_valid || w_s2_ready;
    assign w_accept    = i_vertex.valid && w_s1_ready;

    assign i_vertex.ready = w_s1_ready;

    always_comb begin
        w_ctrl.s1_en      = w_accept;
        w_ctrl.s2_en      = r_s1_valid && w_s2_ready;
        w_ctrl.fold_en    = w_fold;
        w_ctrl.fold_final = r_s2_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_final  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s2_final  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= i_vertex.valid;
                r_s1_final <= i_vertex.final_vertex;
            end
            if (w_s2_ready) begin
                r_s2_valid <= r_s1_valid;
                r_s2_final <= r_s1_final;
            end
            if (w_fold && r_s2_final) begin
                r_res_valid <= 1'b1;
            end else if (w_res_load) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign w_vertex[0] = i_vertex.vertex_x;
    assign w_vertex[1] = i_vertex.vertex_y;
    assign w_vertex[2] = i_vertex.vertex_z;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        tpbb_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_vertex   (w_vertex),
            .i_row      (r_row[a]),
            .i_offset   (r_offset[a]),
            .o_res_low  (w_res_low[a]),
            .o_res_high (w_res_high[a])
        );
    end

    tpbb_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_res_valid),
        .i_low   (w_res_low),
        .i_high  (w_res_high),
        .o_free  (w_out_free),
        .o_box   (o_box)
    );

    // A closed box is only written over when the one before it is leaving.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.fold_en && w_ctrl.fold_final |-> !r_res_valid || w_res_load)
        else $error("closed box overwritten before it was taken");

    a_final_sets_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.fold_en && w_ctrl.fold_final |=> r_res_valid)
        else $error("closing vertex did not produce a pending box");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !w_out_free |=> r_res_valid)
        else $error("pending box lost while the output was stalled");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_valid)
        else $error("accepted vertex missing from the first stage");

endmodule
